### src/ast_pkg.sv
// Shared types, codes and character classes for the assembler source tokenizer.
package ast_pkg;

   localparam int MAX_TOKEN_LEN = 512;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int MAX_RES       = 3;
   localparam int CNT_W         = $clog2(MAX_RES + 1);

   localparam logic [3:0] K_EOL      = 4'd0;
   localparam logic [3:0] K_LOCAL    = 4'd1;
   localparam logic [3:0] K_INDIRECT = 4'd2;
   localparam logic [3:0] K_COLON    = 4'd3;
   localparam logic [3:0] K_INT      = 4'd4;
   localparam logic [3:0] K_FLOAT    = 4'd5;
   localparam logic [3:0] K_IDENT    = 4'd6;
   localparam logic [3:0] K_STRING   = 4'd7;
   localparam logic [3:0] K_CHAR     = 4'd8;
   localparam logic [3:0] K_ERROR    = 4'd9;

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_COMMENT = 4'd1;
   localparam logic [3:0] M_HEX     = 4'd2;
   localparam logic [3:0] M_NUM     = 4'd3;
   localparam logic [3:0] M_MINUS   = 4'd4;
   localparam logic [3:0] M_IDENT   = 4'd5;
   localparam logic [3:0] M_STRING  = 4'd6;
   localparam logic [3:0] M_CHAR    = 4'd7;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
   localparam logic [2:0] ERR_BACKSLASH = 3'd2;
   localparam logic [2:0] ERR_MINUS     = 3'd3;
   localparam logic [2:0] ERR_DOT       = 3'd4;
   localparam logic [2:0] ERR_OPEN      = 3'd5;
   localparam logic [2:0] ERR_EMPTY     = 3'd6;
   localparam logic [2:0] ERR_LONG      = 3'd7;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  content_byte;
      logic        token_start;
      logic        token_end;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [2:0]  error_code;
      logic        error_counts;
      logic        errors_seen;
      logic        last;
   } item_type;

   typedef item_type [MAX_RES-1:0] item_vec_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      item_vec_type     items;
   } step_type;

   typedef struct packed {
      logic [3:0]       mode;
      logic             bs;
      logic             dot;
      logic             bad;
      logic [LEN_W-1:0] len;
      logic [15:0]      line;
      logic [15:0]      col;
      logic [15:0]      tline;
      logic [15:0]      tcol;
      logic             eflag;
   } lex_state_type;

   localparam lex_state_type RESET_STATE = '{
      mode: M_IDLE, bs: 1'b0, dot: 1'b0, bad: 1'b0, len: '0,
      line: 16'd1, col: 16'd1, tline: 16'd1, tcol: 16'd1, eflag: 1'b0};

   function automatic logic is_dig(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return is_dig(c) || is_alpha(c) || c == CH_DOT || c == CH_USCORE;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
   endfunction

   function automatic logic [3:0] tok_kind(input logic [3:0] mode, input logic dot);
      logic [3:0] k;
      case (mode)
         M_NUM, M_MINUS: k = dot ? K_FLOAT : K_INT;
         M_IDENT:        k = K_IDENT;
         M_STRING:       k = K_STRING;
         M_CHAR:         k = K_CHAR;
         default:        k = K_INT;
      endcase
      return k;
   endfunction

   function automatic item_type mk_item(input logic [3:0] kind, input logic [7:0] b,
                                        input logic st, input logic en,
                                        input logic [15:0] ln, input logic [15:0] col,
                                        input logic [2:0] err, input logic cnt);
      item_type x;
      x.kind         = kind;
      x.content_byte = b;
      x.token_start  = st;
      x.token_end    = en;
      x.start_line   = ln;
      x.start_column = col;
      x.error_code   = err;
      x.error_counts = cnt;
      x.errors_seen  = 1'b0;
      x.last         = 1'b0;
      return x;
   endfunction

endpackage

### src/ast_core.sv
// Lexer state and the per-byte classification that yields up to three result beats.
module ast_core (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   input  logic               take,
   output ast_pkg::step_type  step
);
   import ast_pkg::*;

   lex_state_type    state_ff, state_in;
   lex_state_type    s;
   item_vec_type     r;
   logic [CNT_W-1:0] n;
   logic             go_idle;
   logic             skip;
   logic [7:0]       c;
   logic [7:0]       q;

   function automatic void put(inout lex_state_type st, inout item_vec_type rv,
                               inout logic [CNT_W-1:0] cnt, input item_type x);
      item_type y;
      y = x;
      if (x.error_counts) st.eflag = 1'b1;
      y.errors_seen = st.eflag;
      if (cnt < CNT_W'(MAX_RES)) begin
         rv[cnt] = y;
         cnt = cnt + CNT_W'(1);
      end
   endfunction

   function automatic void content(inout lex_state_type st, inout item_vec_type rv,
                                   inout logic [CNT_W-1:0] cnt, input logic [7:0] b,
                                   input logic [2:0] e, input logic ec);
      logic [2:0] ee;
      logic       cc;
      ee = e;
      cc = ec;
      if (e == ERR_NONE && st.len == LEN_W'(MAX_TOKEN_LEN - 1)) begin
         ee = ERR_LONG;
         cc = 1'b1;
      end
      put(st, rv, cnt, mk_item(tok_kind(st.mode, st.dot), b, st.len == '0, 1'b0,
                               st.tline, st.tcol, ee, cc));
      if (st.len < LEN_W'(MAX_TOKEN_LEN)) st.len = st.len + LEN_W'(1);
   endfunction

   function automatic void close_tok(inout lex_state_type st, inout item_vec_type rv,
                                     inout logic [CNT_W-1:0] cnt,
                                     input logic [2:0] e, input logic ec);
      put(st, rv, cnt, mk_item(tok_kind(st.mode, st.dot), CH_NUL, st.len == '0, 1'b1,
                               st.tline, st.tcol, e, ec));
      st.mode = M_IDLE;
      st.len  = '0;
      st.dot  = 1'b0;
      st.bad  = 1'b0;
      st.bs   = 1'b0;
   endfunction

   function automatic void open_tok(inout lex_state_type st, input logic [3:0] mode);
      st.mode  = mode;
      st.tline = st.line;
      st.tcol  = st.col;
      st.len   = '0;
      st.dot   = 1'b0;
      st.bad   = 1'b0;
      st.bs    = 1'b0;
   endfunction

   always_comb begin
      s       = state_ff;
      r       = '0;
      n       = '0;
      go_idle = 1'b0;
      skip    = 1'b0;
      c       = req_text_byte;
      q       = CH_DQUOTE;
      if (req_end_of_text || c == CH_NUL) begin
         case (s.mode)
            M_HEX, M_IDENT: close_tok(s, r, n, ERR_NONE, 1'b0);
            M_MINUS:        close_tok(s, r, n, ERR_MINUS, 1'b1);
            M_NUM: begin
               if (s.bad) close_tok(s, r, n, ERR_DOT, 1'b1);
               else close_tok(s, r, n, ERR_NONE, 1'b0);
            end
            M_STRING, M_CHAR: close_tok(s, r, n, ERR_OPEN, 1'b0);
            M_IDLE: begin
               if (s.bs) put(s, r, n, mk_item(K_ERROR, CH_NUL, 1'b0, 1'b0, s.line, s.col,
                                              ERR_BACKSLASH, 1'b0));
            end
            default: ;
         endcase
         put(s, r, n, mk_item(K_EOL, CH_NUL, 1'b1, 1'b1, s.line, s.col, ERR_NONE, 1'b0));
         s = RESET_STATE;
      end else begin
         if (c == CH_LF) begin
            if (s.line != 16'hFFFF) s.line = s.line + 16'd1;
            s.col = '0;
         end else if (s.col != 16'hFFFF) begin
            s.col = s.col + 16'd1;
         end
         case (s.mode)
            M_COMMENT: begin
               if (c == CH_LF) begin
                  s.mode  = M_IDLE;
                  go_idle = 1'b1;
               end
            end
            M_HEX: begin
               if (is_hex(c)) content(s, r, n, c, ERR_NONE, 1'b0);
               else begin
                  close_tok(s, r, n, ERR_NONE, 1'b0);
                  go_idle = 1'b1;
               end
            end
            M_MINUS: begin
               if (is_dig(c)) begin
                  s.mode = M_NUM;
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end else if (c == CH_DOT) begin
                  s.mode = M_NUM;
                  s.dot  = 1'b1;
                  content(s, r, n, c, ERR_MINUS, 1'b1);
               end else begin
                  close_tok(s, r, n, ERR_MINUS, 1'b1);
                  go_idle = 1'b1;
               end
            end
            M_NUM: begin
               if (is_dig(c)) content(s, r, n, c, ERR_NONE, 1'b0);
               else if (c == CH_DOT) begin
                  if (s.dot) begin
                     s.bad = 1'b1;
                     content(s, r, n, c, ERR_DOT, 1'b1);
                  end else begin
                     s.dot = 1'b1;
                     content(s, r, n, c, ERR_NONE, 1'b0);
                  end
               end else begin
                  if (s.bad) close_tok(s, r, n, ERR_DOT, 1'b1);
                  else close_tok(s, r, n, ERR_NONE, 1'b0);
                  go_idle = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_name(c)) content(s, r, n, c, ERR_NONE, 1'b0);
               else begin
                  close_tok(s, r, n, ERR_NONE, 1'b0);
                  go_idle = 1'b1;
               end
            end
            M_STRING, M_CHAR: begin
               q = (s.mode == M_STRING) ? CH_DQUOTE : CH_SQUOTE;
               if (c == q && !s.bs) begin
                  if (s.mode == M_CHAR && s.len == '0) close_tok(s, r, n, ERR_EMPTY, 1'b1);
                  else close_tok(s, r, n, ERR_NONE, 1'b0);
               end else begin
                  s.bs = (c == CH_BSL);
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end
            end
            default: begin
               s.mode  = M_IDLE;
               go_idle = 1'b1;
            end
         endcase
         if (go_idle) begin
            if (s.bs) begin
               s.bs = 1'b0;
               if (c == CH_LF) skip = 1'b1;
               else put(s, r, n, mk_item(K_ERROR, CH_NUL, 1'b0, 1'b0, s.line, s.col,
                                         ERR_BACKSLASH, 1'b0));
            end
            if (!skip) begin
               if (c == CH_LF)
                  put(s, r, n, mk_item(K_EOL, CH_NUL, 1'b1, 1'b1, s.line, s.col,
                                       ERR_NONE, 1'b0));
               else if (c == CH_BSL) s.bs = 1'b1;
               else if (c == CH_SEMI) s.mode = M_COMMENT;
               else if (is_blank(c)) s.bs = 1'b0;
               else if (c == CH_HASH)
                  put(s, r, n, mk_item(K_LOCAL, CH_NUL, 1'b1, 1'b1, s.line, s.col,
                                       ERR_NONE, 1'b0));
               else if (c == CH_STAR)
                  put(s, r, n, mk_item(K_INDIRECT, CH_NUL, 1'b1, 1'b1, s.line, s.col,
                                       ERR_NONE, 1'b0));
               else if (c == CH_COLON)
                  put(s, r, n, mk_item(K_COLON, CH_NUL, 1'b1, 1'b1, s.line, s.col,
                                       ERR_NONE, 1'b0));
               else if (c == CH_DOLLAR) begin
                  open_tok(s, M_HEX);
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end else if (is_dig(c)) begin
                  open_tok(s, M_NUM);
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end else if (c == CH_MINUS) begin
                  open_tok(s, M_MINUS);
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end else if (is_name(c)) begin
                  open_tok(s, M_IDENT);
                  content(s, r, n, c, ERR_NONE, 1'b0);
               end else if (c == CH_DQUOTE) open_tok(s, M_STRING);
               else if (c == CH_SQUOTE) open_tok(s, M_CHAR);
               else
                  put(s, r, n, mk_item(K_ERROR, CH_NUL, 1'b0, 1'b0, s.line, s.col,
                                       ERR_BAD_CHAR, 1'b1));
            end
         end
      end
      if (n != '0) r[n - CNT_W'(1)].last = 1'b1;
      step.count = n;
      step.items = r;
      state_in   = take ? s : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/ast_resq.sv
// Result register holding one byte's beats, handed out one per cycle with rsp_ready high.
module ast_resq (
   input  logic               clock,
   input  logic               reset,
   input  ast_pkg::step_type  step,
   input  logic               load,
   input  logic               rsp_ready,
   output logic               take_ok,
   output logic               head_valid,
   output ast_pkg::item_type  head
);
   import ast_pkg::*;

   item_vec_type     slot_ff, slot_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic             pop;

   assign head_valid = (level_ff != '0);
   assign head       = slot_ff[0];
   assign pop        = head_valid && rsp_ready;
   assign take_ok    = (level_ff == '0) || (level_ff == CNT_W'(1) && rsp_ready);

   always_comb begin
      slot_in  = slot_ff;
      level_in = level_ff;
      if (load) begin
         slot_in  = step.items;
         level_in = step.count;
      end else if (pop) begin
         slot_in  = item_vec_type'(slot_ff >> $bits(item_type));
         level_in = level_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

### src/assembler_source_tokenizer.sv
// Top level of the assembler source tokenizer: lexer core, result register and checks.
// Source text goes in one byte per beat; while rsp_ready is high, token beats come out one
// per cycle, the first in the cycle after the byte is taken, a byte that yields one result
// or none does not hold the input and plain text streams at one byte per cycle. A byte that
// yields two beats (a token closed by the next token, a stray backslash, the end of text
// behind an open token or a backslash) holds the input until one beat is left, as the
// single result port drains one beat at a time. A zero byte or end_of_text closes any
// open token, emits a final eol and returns the lexer to its reset state for the next text.
module assembler_source_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_content_byte,
   output logic        rsp_token_start,
   output logic        rsp_token_end,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_error_counts,
   output logic        rsp_errors_seen,
   output logic        rsp_last
);
   import ast_pkg::*;

   step_type step;
   item_type head;
   logic     take;

   assign take = req_valid && req_ready;

   ast_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .take            (take),
      .step            (step)
   );

   ast_resq u_resq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .load       (take),
      .rsp_ready  (rsp_ready),
      .take_ok    (req_ready),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_content_byte = head.content_byte;
   assign rsp_token_start  = head.token_start;
   assign rsp_token_end    = head.token_end;
   assign rsp_start_line   = head.start_line;
   assign rsp_start_column = head.start_column;
   assign rsp_error_code   = head.error_code;
   assign rsp_error_counts = head.error_counts;
   assign rsp_errors_seen  = head.errors_seen;
   assign rsp_last         = head.last;

   // end of text always leaves at least the final eol
   a_eot_gives_beat: assert property (@(posedge clock) disable iff (reset)
      take && (req_end_of_text || req_text_byte == CH_NUL) |=> rsp_valid)
      else $error("end of text produced no beat");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("beat group cut short");

   a_sticky_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last && rsp_errors_seen |=> rsp_errors_seen)
      else $error("error flag dropped within a group");

   a_count_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_counts |-> rsp_errors_seen)
      else $error("counting error without sticky flag");

endmodule

### tb/sv/tb_assembler_source_tokenizer.sv
// Self-checking testbench for the assembler source tokenizer: queued byte stimulus, token check.
`timescale 1ns / 100ps

module tb_assembler_source_tokenizer;
   import ast_pkg::*;

   localparam int QUIET_FROM = 150;
   localparam int QUIET_TO   = 400;

   localparam string LEAD_POOL  = "abqxzABXZ_.";
   localparam string NAME_POOL  = "abcfxyzAFQZ019._";
   localparam string HEX_POOL   = "0123456789abcdefABCDEF";
   localparam string DIGIT_POOL = "0123456789";

   typedef struct {
      logic [7:0] ch;
      logic       eot;
      logic       drain;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_content_byte;
   logic        rsp_token_start;
   logic        rsp_token_end;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [2:0]  rsp_error_code;
   logic        rsp_error_counts;
   logic        rsp_errors_seen;
   logic        rsp_last;

   text_beat_type text_q[$];
   item_type    token_q[$];
   logic        hold_next = 1'b0;
   int unsigned cyc = 0;
   int unsigned cycle_limit = 32'hFFFF_FFFF;
   int unsigned bad_cnt = 0;
   logic        gaps_on;

   // lexer shadow state
   logic [3:0]  lx_mode;
   logic        lx_bs;
   logic        lx_dot;
   logic        lx_bad;
   logic [9:0]  lx_len;
   logic [15:0] ln_cnt;
   logic [15:0] col_cnt;
   logic [15:0] tok_ln;
   logic [15:0] tok_col;
   logic        err_sticky;
   item_type    step_buf[MAX_RES];
   int          step_n;

   assembler_source_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_content_byte (rsp_content_byte),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_end    (rsp_token_end),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_error_code   (rsp_error_code),
      .rsp_error_counts (rsp_error_counts),
      .rsp_errors_seen  (rsp_errors_seen),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   assign gaps_on = !(cyc >= QUIET_FROM && cyc < QUIET_TO);

   // ---------------------------------------------------------------- prediction

   function automatic logic digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic hex_ch(input logic [7:0] c);
      return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic name_ch(input logic [7:0] c);
      return digit_ch(c) || letter_ch(c) || c == CH_DOT || c == CH_USCORE;
   endfunction

   function automatic logic blank_ch(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D && c != CH_LF);
   endfunction

   function automatic logic [3:0] open_kind();
      case (lx_mode)
         M_NUM, M_MINUS: return lx_dot ? K_FLOAT : K_INT;
         M_IDENT:        return K_IDENT;
         M_STRING:       return K_STRING;
         M_CHAR:         return K_CHAR;
         default:        return K_INT;
      endcase
   endfunction

   task automatic lex_reset();
      lx_mode    = M_IDLE;
      lx_bs      = 1'b0;
      lx_dot     = 1'b0;
      lx_bad     = 1'b0;
      lx_len     = '0;
      ln_cnt     = 16'd1;
      col_cnt    = 16'd1;
      tok_ln     = 16'd1;
      tok_col    = 16'd1;
      err_sticky = 1'b0;
   endtask

   task automatic emit(input logic [3:0] k, input logic [7:0] b, input logic st,
                       input logic en, input logic [15:0] ln, input logic [15:0] col,
                       input logic [2:0] err, input logic cnt);
      item_type x;
      if (step_n >= MAX_RES) return;
      if (cnt) err_sticky = 1'b1;
      x.kind         = k;
      x.content_byte = b;
      x.token_start  = st;
      x.token_end    = en;
      x.start_line   = ln;
      x.start_column = col;
      x.error_code   = err;
      x.error_counts = cnt;
      x.errors_seen  = err_sticky;
      x.last         = 1'b0;
      step_buf[step_n] = x;
      step_n++;
   endtask

   task automatic tok_open(input logic [3:0] mode);
      lx_mode = mode;
      tok_ln  = ln_cnt;
      tok_col = col_cnt;
      lx_len  = '0;
      lx_dot  = 1'b0;
      lx_bad  = 1'b0;
      lx_bs   = 1'b0;
   endtask

   task automatic tok_byte(input logic [7:0] c, input logic [2:0] err_in, input logic cnt_in);
      logic [2:0] err;
      logic       cnt;
      err = err_in;
      cnt = cnt_in;
      if (err == ERR_NONE && lx_len == MAX_TOKEN_LEN - 1) begin
         err = ERR_LONG;
         cnt = 1'b1;
      end
      emit(open_kind(), c, lx_len == 0, 1'b0, tok_ln, tok_col, err, cnt);
      if (lx_len < MAX_TOKEN_LEN) lx_len++;
   endtask

   task automatic tok_close(input logic [2:0] err, input logic cnt);
      emit(open_kind(), 8'h00, lx_len == 0, 1'b1, tok_ln, tok_col, err, cnt);
      lx_mode = M_IDLE;
      lx_len  = '0;
      lx_dot  = 1'b0;
      lx_bad  = 1'b0;
      lx_bs   = 1'b0;
   endtask

   task automatic single_tok(input logic [3:0] k);
      emit(k, 8'h00, 1'b1, 1'b1, ln_cnt, col_cnt, ERR_NONE, 1'b0);
   endtask

   task automatic lex_idle(input logic [7:0] c);
      if (lx_bs) begin
         lx_bs = 1'b0;
         if (c == CH_LF) return;
         emit(K_ERROR, 8'h00, 1'b0, 1'b0, ln_cnt, col_cnt, ERR_BACKSLASH, 1'b0);
      end
      if (c == CH_LF) single_tok(K_EOL);
      else if (c == CH_BSL) lx_bs = 1'b1;
      else if (c == CH_SEMI) lx_mode = M_COMMENT;
      else if (blank_ch(c)) begin
      end else if (c == CH_HASH) single_tok(K_LOCAL);
      else if (c == CH_STAR) single_tok(K_INDIRECT);
      else if (c == CH_COLON) single_tok(K_COLON);
      else if (c == CH_DOLLAR) begin
         tok_open(M_HEX);
         tok_byte(c, ERR_NONE, 1'b0);
      end else if (digit_ch(c)) begin
         tok_open(M_NUM);
         tok_byte(c, ERR_NONE, 1'b0);
      end else if (c == CH_MINUS) begin
         tok_open(M_MINUS);
         tok_byte(c, ERR_NONE, 1'b0);
      end else if (name_ch(c)) begin
         tok_open(M_IDENT);
         tok_byte(c, ERR_NONE, 1'b0);
      end else if (c == CH_DQUOTE) tok_open(M_STRING);
      else if (c == CH_SQUOTE) tok_open(M_CHAR);
      else emit(K_ERROR, 8'h00, 1'b0, 1'b0, ln_cnt, col_cnt, ERR_BAD_CHAR, 1'b1);
   endtask

   task automatic lex_take(input logic [7:0] c);
      logic [7:0] q;
      case (lx_mode)
         M_COMMENT: begin
            if (c == CH_LF) begin
               lx_mode = M_IDLE;
               lex_idle(c);
            end
         end
         M_HEX: begin
            if (hex_ch(c)) tok_byte(c, ERR_NONE, 1'b0);
            else begin
               tok_close(ERR_NONE, 1'b0);
               lex_idle(c);
            end
         end
         M_MINUS: begin
            if (digit_ch(c)) begin
               lx_mode = M_NUM;
               tok_byte(c, ERR_NONE, 1'b0);
            end else if (c == CH_DOT) begin
               lx_mode = M_NUM;
               lx_dot  = 1'b1;
               tok_byte(c, ERR_MINUS, 1'b1);
            end else begin
               tok_close(ERR_MINUS, 1'b1);
               lex_idle(c);
            end
         end
         M_NUM: begin
            if (digit_ch(c)) tok_byte(c, ERR_NONE, 1'b0);
            else if (c == CH_DOT) begin
               if (lx_dot) begin
                  lx_bad = 1'b1;
                  tok_byte(c, ERR_DOT, 1'b1);
               end else begin
                  lx_dot = 1'b1;
                  tok_byte(c, ERR_NONE, 1'b0);
               end
            end else begin
               if (lx_bad) tok_close(ERR_DOT, 1'b1);
               else tok_close(ERR_NONE, 1'b0);
               lex_idle(c);
            end
         end
         M_IDENT: begin
            if (name_ch(c)) tok_byte(c, ERR_NONE, 1'b0);
            else begin
               tok_close(ERR_NONE, 1'b0);
               lex_idle(c);
            end
         end
         M_STRING, M_CHAR: begin
            q = (lx_mode == M_STRING) ? CH_DQUOTE : CH_SQUOTE;
            if (c == q && !lx_bs) begin
               if (lx_mode == M_CHAR && lx_len == 0) tok_close(ERR_EMPTY, 1'b1);
               else tok_close(ERR_NONE, 1'b0);
            end else begin
               lx_bs = (c == CH_BSL);
               tok_byte(c, ERR_NONE, 1'b0);
            end
         end
         default: begin
            lx_mode = M_IDLE;
            lex_idle(c);
         end
      endcase
   endtask

   task automatic text_close();
      case (lx_mode)
         M_HEX, M_IDENT:   tok_close(ERR_NONE, 1'b0);
         M_MINUS:          tok_close(ERR_MINUS, 1'b1);
         M_NUM: begin
            if (lx_bad) tok_close(ERR_DOT, 1'b1);
            else tok_close(ERR_NONE, 1'b0);
         end
         M_STRING, M_CHAR: tok_close(ERR_OPEN, 1'b0);
         M_IDLE: begin
            if (lx_bs)
               emit(K_ERROR, 8'h00, 1'b0, 1'b0, ln_cnt, col_cnt, ERR_BACKSLASH, 1'b0);
         end
         default: begin
         end
      endcase
      single_tok(K_EOL);
   endtask

   task automatic tokenize_beat(input logic [7:0] c, input logic eot);
      step_n = 0;
      if (eot || c == CH_NUL) begin
         text_close();
         lex_reset();
      end else begin
         if (c == CH_LF) begin
            if (ln_cnt != 16'hFFFF) ln_cnt++;
            col_cnt = 16'd0;
         end else if (col_cnt != 16'hFFFF) begin
            col_cnt++;
         end
         lex_take(c);
      end
      if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) token_q.push_back(step_buf[i]);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] pick(input string p);
      return p[$urandom_range(p.len() - 1)];
   endfunction

   task automatic push_ch(input logic [7:0] c);
      text_beat_type b;
      b.ch    = c;
      b.eot   = 1'b0;
      b.drain = hold_next;
      hold_next = 1'b0;
      text_q.push_back(b);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) push_ch(s[i]);
   endtask

   // end of text, either by the flag (byte then random) or by a zero byte
   task automatic push_end(input logic by_flag);
      text_beat_type b;
      b.eot   = by_flag;
      b.ch    = by_flag ? 8'($urandom) : CH_NUL;
      b.drain = hold_next;
      hold_next = 1'b0;
      text_q.push_back(b);
   endtask

   task automatic push_digits(input int lo, input int hi);
      repeat ($urandom_range(hi, lo)) push_ch(pick(DIGIT_POOL));
   endtask

   task automatic push_lit(input logic [7:0] q);
      logic [7:0] c;
      if ($urandom_range(4) == 0) begin
         push_ch(CH_BSL);
         push_ch(q);
      end else begin
         c = 8'($urandom_range(255, 32));
         if (c == q || c == CH_BSL) c = "z";
         push_ch(c);
      end
   endtask

   task automatic gen_token();
      case ($urandom_range(13))
         0: begin
            push_ch(pick(LEAD_POOL));
            repeat ($urandom_range(6)) push_ch(pick(NAME_POOL));
         end
         1: begin
            push_ch(CH_DOLLAR);
            repeat ($urandom_range(4)) push_ch(pick(HEX_POOL));
         end
         2: push_digits(1, 4);
         3: begin
            push_digits(1, 3);
            push_ch(CH_DOT);
            push_digits(0, 3);
            if ($urandom_range(3) == 0) begin
               push_ch(CH_DOT);
               push_digits(0, 2);
            end
         end
         4: begin
            push_ch(CH_MINUS);
            case ($urandom_range(3))
               0: begin
               end
               1: push_digits(1, 3);
               2: begin
                  push_digits(1, 2);
                  push_ch(CH_DOT);
                  push_digits(0, 2);
               end
               default: begin
                  push_ch(CH_DOT);
                  push_digits(0, 2);
               end
            endcase
         end
         5: begin
            push_ch(CH_DQUOTE);
            repeat ($urandom_range(5)) push_lit(CH_DQUOTE);
            push_ch(CH_DQUOTE);
         end
         6: begin
            push_ch(CH_SQUOTE);
            repeat ($urandom_range(1)) push_lit(CH_SQUOTE);
            push_ch(CH_SQUOTE);
         end
         7: push_ch(CH_HASH);
         8: push_ch(CH_STAR);
         9: push_ch(CH_COLON);
         10: begin
            push_ch(CH_SEMI);
            repeat ($urandom_range(8)) push_ch(8'($urandom_range(126, 32)));
            push_ch(CH_LF);
         end
         11: begin
            push_ch(CH_BSL);
            push_ch(CH_LF);
         end
         12: push_ch(CH_LF);
         default: push_ch(8'($urandom_range(255)));
      endcase
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : driver
      logic          go;
      text_beat_type cur;
      go = 1'b0;
      if (reset) begin
         lex_reset();
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) tokenize_beat(req_text_byte, req_end_of_text);
         if (!req_valid || req_ready) begin
            if (text_q.size() != 0 && !(text_q[0].drain && token_q.size() != 0))
               go = !(gaps_on && $urandom_range(99) < 38);
            if (go) begin
               cur = text_q.pop_front();
               req_text_byte   <= cur.ch;
               req_end_of_text <= cur.eot;
            end
            req_valid <= go;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      item_type got;
      item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_content_byte, rsp_token_start, rsp_token_end,
                   rsp_start_line, rsp_start_column, rsp_error_code, rsp_error_counts,
                   rsp_errors_seen, rsp_last};
            if (token_q.size() == 0) begin
               if (bad_cnt < 10)
                  $display("unexpected token beat: kind %0d byte %02h line %0d col %0d",
                           got.kind, got.content_byte, got.start_line, got.start_column);
               bad_cnt++;
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  if (bad_cnt < 10) begin
                     $write("token beat mismatch (exp/got): kind %0d/%0d byte %02h/%02h",
                            want.kind, got.kind, want.content_byte, got.content_byte);
                     $write(" st %b/%b en %b/%b line %0d/%0d col %0d/%0d err %0d/%0d",
                            want.token_start, got.token_start,
                            want.token_end, got.token_end,
                            want.start_line, got.start_line,
                            want.start_column, got.start_column,
                            want.error_code, got.error_code);
                     $display(" cnt %b/%b seen %b/%b last %b/%b",
                              want.error_counts, got.error_counts,
                              want.errors_seen, got.errors_seen, want.last, got.last);
                  end
                  bad_cnt++;
               end
            end
         end
         rsp_ready <= !(gaps_on && $urandom_range(99) < 38);
      end
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > cycle_limit) begin
         $display("timeout after %0d cycles", cyc);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int unsigned base;
      int unsigned t0;
      int unsigned span;
      int unsigned texts;
      texts = 0;

      // single-char tokens, hex, minus-dot, second dot, bare minus, escaped quote,
      // empty char, stray backslash, continuation, bad char, comment, open literal
      push_str("#*:$F-.5.-x\"\\\"\"''\\q\\");
      push_ch(CH_LF);
      push_ch(8'hFF);
      push_ch(CH_SEMI);
      push_ch(CH_LF);
      push_str("'a");
      push_end(1'b1);
      // empty string, backslash right before the end
      push_str("\"\"\\");
      push_end(1'b0);

      base = text_q.size();
      while (text_q.size() - base < 230) begin
         hold_next = (texts == 0) || ($urandom_range(3) == 0);
         span = $urandom_range(50, 10);
         t0 = text_q.size();
         while (text_q.size() - t0 < span) begin
            gen_token();
            if ($urandom_range(1)) push_ch($urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9)));
         end
         push_end(1'($urandom_range(1)));
         texts++;
      end

      cycle_limit = 40 * text_q.size() + 20000;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_valid) @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (bad_cnt == 0 && token_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
src/ast_pkg.sv
src/ast_core.sv
src/ast_resq.sv
src/assembler_source_tokenizer.sv
tb/sv/tb_assembler_source_tokenizer.sv
